### rtl/core/particulate_frame_parser_unit_assert.svh
// Assertion macros for the particulate frame parser RTL, used by pfp_frame_core.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef PARTICULATE_FRAME_PARSER_UNIT_ASSERT_SVH
`define PARTICULATE_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define PFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfp assertion failed: same-cycle implication");

// Next-cycle implication, checked only outside reset.
`define PFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfp assertion failed: next-cycle implication");

`endif

### rtl/core/pfp_pkg.sv
// Package for the particulate frame parser: payload widths, frame constants and types.
// No dependencies; all other RTL files but the assertion header use it by scoped names.
package pfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ReadW  = 16;
  localparam int unsigned PosW   = 4;

  // Frame layout: eleven bytes, header at 0 and 1, readings at 6..9, checksum at 10.
  localparam logic [PosW-1:0] PosHdr0    = 4'd0;
  localparam logic [PosW-1:0] PosHdr1    = 4'd1;
  localparam logic [PosW-1:0] PosFineHi  = 4'd6;
  localparam logic [PosW-1:0] PosFineLo  = 4'd7;
  localparam logic [PosW-1:0] PosCoarseHi = 4'd8;
  localparam logic [PosW-1:0] PosCoarseLo = 4'd9;
  localparam logic [PosW-1:0] PosLast    = 4'd10;

  localparam logic [ByteW-1:0] Hdr0Byte = 8'hFE;
  localparam logic [ByteW-1:0] Hdr1Byte = 8'hA5;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_GOOD     = 1'b0,
    STATUS_CHECKSUM = 1'b1
  } status_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [ReadW-1:0] fine_reading;
    logic [ReadW-1:0] coarse_reading;
  } result_t;

endpackage

### rtl/core/pfp_in_if.sv
// Input channel interface of the particulate frame parser (valid/ready plus one item).
// Depends on pfp_pkg for the payload widths.
interface pfp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [pfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

### rtl/core/pfp_out_if.sv
// Result channel interface of the particulate frame parser (valid/ready plus one item).
// Depends on pfp_pkg for the payload widths.
interface pfp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [pfp_pkg::ReadW-1:0] fine_reading;
  logic [pfp_pkg::ReadW-1:0] coarse_reading;

  modport source (output valid, output status, output fine_reading, output coarse_reading,
                  input ready);
  modport sink   (input valid, input status, input fine_reading, input coarse_reading,
                  output ready);
endinterface

### rtl/core/pfp_in_stage.sv
// Input register of the particulate frame parser: holds one accepted item.
// Depends on pfp_pkg for the item type.
module pfp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  pfp_pkg::item_t in_item_i,
  output logic           in_ready_o,
  input  logic           advance_i,
  output logic           vld_o,
  output pfp_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  pfp_pkg::item_t item_q;
  logic           load;

  // The register frees up in the same cycle its item moves on.
  assign in_ready_o = !vld_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

### rtl/core/pfp_frame_core.sv
// Frame tracking of the particulate frame parser: position, header check, checksum, readings.
// Depends on pfp_pkg and on the assertion macro header.
`include "particulate_frame_parser_unit_assert.svh"

module pfp_frame_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  pfp_pkg::item_t   item_i,
  output logic             has_result_o,
  output pfp_pkg::result_t result_o
);

  logic [pfp_pkg::PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [pfp_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      hdr_q, hdr_d;
  logic [pfp_pkg::ReadW-1:0] fine_q, fine_d;
  logic [pfp_pkg::ReadW-1:0] coarse_q, coarse_d;
  logic                      flush;
  logic                      sum_ok;
  logic [pfp_pkg::ByteW-1:0] b;
  logic                      bad_sum_out;
  logic                      readings_zero;
  logic                      last_step;

  assign b       = item_i.rx_byte;
  assign flush   = (item_i.kind == pfp_pkg::KIND_FLUSH);
  // A position beyond the last byte cannot occur; it would count as a frame start.
  assign pos_eff = (pos_q > pfp_pkg::PosLast) ? pfp_pkg::PosHdr0 : pos_q;
  assign sum_ok  = (sum_q == b);

  assign has_result_o = !flush && (pos_eff == pfp_pkg::PosLast) && hdr_q;

  always_comb begin
    result_o.status         = sum_ok ? pfp_pkg::STATUS_GOOD : pfp_pkg::STATUS_CHECKSUM;
    result_o.fine_reading   = sum_ok ? fine_q : '0;
    result_o.coarse_reading = sum_ok ? coarse_q : '0;
  end

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    hdr_d    = hdr_q;
    fine_d   = fine_q;
    coarse_d = coarse_q;
    if (step_en_i) begin
      if (flush) begin
        pos_d = pfp_pkg::PosHdr0;
      end else begin
        pos_d = (pos_eff == pfp_pkg::PosLast) ? pfp_pkg::PosHdr0
                                              : pos_eff + pfp_pkg::PosW'(1);
        if (pos_eff == pfp_pkg::PosHdr0) begin
          hdr_d = (b == pfp_pkg::Hdr0Byte);
          sum_d = '0;
        end else if (pos_eff != pfp_pkg::PosLast) begin
          sum_d = sum_q + b;
          unique case (pos_eff)
            pfp_pkg::PosHdr1:     hdr_d = hdr_q && (b == pfp_pkg::Hdr1Byte);
            pfp_pkg::PosFineHi:   fine_d = {b, fine_q[pfp_pkg::ByteW-1:0]};
            pfp_pkg::PosFineLo:   fine_d = {fine_q[pfp_pkg::ReadW-1:pfp_pkg::ByteW], b};
            pfp_pkg::PosCoarseHi: coarse_d = {b, coarse_q[pfp_pkg::ByteW-1:0]};
            pfp_pkg::PosCoarseLo: coarse_d = {coarse_q[pfp_pkg::ReadW-1:pfp_pkg::ByteW], b};
            default:              ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      hdr_q    <= 1'b0;
      fine_q   <= '0;
      coarse_q <= '0;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      hdr_q    <= hdr_d;
      fine_q   <= fine_d;
      coarse_q <= coarse_d;
    end
  end

  assign bad_sum_out   = has_result_o && (result_o.status == pfp_pkg::STATUS_CHECKSUM);
  assign readings_zero = (result_o.fine_reading == '0) && (result_o.coarse_reading == '0);
  assign last_step     = step_en_i && !flush && (pos_eff == pfp_pkg::PosLast);

  `PFP_ASSERT_IMPL(a_pos_in_range, 1'b1, pos_q <= pfp_pkg::PosLast)
  `PFP_ASSERT_NEXT(a_flush_restarts, step_en_i && flush, pos_q == pfp_pkg::PosHdr0)
  `PFP_ASSERT_IMPL(a_mismatch_zeroes, bad_sum_out, readings_zero)
  `PFP_ASSERT_NEXT(a_last_wraps, last_step, pos_q == pfp_pkg::PosHdr0)

endmodule

### rtl/core/pfp_out_stage.sv
// Result register of the particulate frame parser: holds one result until it is taken.
// Depends on pfp_pkg for the result type.
module pfp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pfp_pkg::result_t result_i,
  output logic             can_take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pfp_pkg::result_t result_o
);

  logic             vld_q, vld_d;
  pfp_pkg::result_t res_q;

  assign can_take_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

### rtl/core/particulate_frame_parser_unit.sv
// Particulate frame parser: one item per cycle sustained on the input channel.
// An accepted byte sits in the input register right after its accepting edge; when a
// frame's last byte moves on, its result is loaded into the result register (pfp_out_stage).
// Throughput: one item every cycle; the only limit is the downstream ready.
// Reset (rst_ni low, asynchronous): pipeline emptied, frame position, sum, header flag
// and readings all cleared, so the first byte after reset starts a frame.
//
// Structure. An input register (pfp_in_stage) takes each item. While the item sits there,
// pfp_frame_core decodes it against the frame position: byte 0 and byte 1 are checked
// against the header pattern, bytes 1 to 9 go into an 8-bit wrapping sum, and bytes 6 to 9
// are gathered into the two big-endian readings. On byte 10 with a good header the core
// offers one result, comparing the sum with the checksum byte. A flush item only sends the
// position back to zero. The result register (pfp_out_stage) holds a result until the sink
// takes it; the input register keeps taking items as long as its item can move on, so a
// waiting result stalls the pipe only when another result is due behind it.
module particulate_frame_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfp_in_if.sink    in_i,
  pfp_out_if.source out_o
);

  pfp_pkg::item_t   in_item;
  pfp_pkg::item_t   s1_item;
  logic             s1_vld;
  logic             advance;
  logic             has_result;
  logic             out_can_take;
  pfp_pkg::result_t core_res;
  pfp_pkg::result_t out_res;

  assign in_item.kind    = in_i.kind;
  assign in_item.rx_byte = in_i.rx_byte;

  // An item that yields no result always moves on; one that yields a result needs room.
  assign advance = s1_vld && (!has_result || out_can_take);

  pfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_i.ready),
    .advance_i  (advance),
    .vld_o      (s1_vld),
    .item_o     (s1_item)
  );

  pfp_frame_core u_frame_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (advance),
    .item_i       (s1_item),
    .has_result_o (has_result),
    .result_o     (core_res)
  );

  pfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (core_res),
    .can_take_o  (out_can_take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_res)
  );

  assign out_o.status         = out_res.status;
  assign out_o.fine_reading   = out_res.fine_reading;
  assign out_o.coarse_reading = out_res.coarse_reading;

endmodule

### bench/particulate_frame_parser_unit_test.sv
`timescale 1ns / 1ps
// Testbench for particulate_frame_parser_unit: random and directed sensor byte streams,
// checked result by result against a frame tracker kept inside the bench.
// Depends on pfp_pkg, pfp_in_if and pfp_out_if from the RTL.
module particulate_frame_parser_unit_test;

  // Shapes of byte groups the stimulus generator can emit. Well-formed frames dominate so
  // that the checksum and reading logic is exercised; the rest breaks the frame.
  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_SUM,
    SHAPE_BAD_HDR0,
    SHAPE_BAD_HDR1,
    SHAPE_CUT,
    SHAPE_NOISE
  } frame_shape_e;

  localparam int TotalItems     = 1950;
  localparam int PauseEvery     = 400;
  localparam int LongHoldCycles = 400;
  localparam int SettleCycles   = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfp_in_if  in_ch ();
  pfp_out_if out_ch ();

  particulate_frame_parser_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Items waiting to be offered, and readings the parser still owes us.
  pfp_pkg::item_t   sensor_bytes_q[$];
  pfp_pkg::result_t due_readings_q[$];

  // Frame tracker state: mirrors what the parser must remember between bytes.
  logic [pfp_pkg::PosW-1:0]  frame_pos     = pfp_pkg::PosHdr0;
  logic [pfp_pkg::ByteW-1:0] frame_sum     = '0;
  logic                      frame_hdr_ok  = 1'b0;
  logic [pfp_pkg::ReadW-1:0] fine_gather   = '0;
  logic [pfp_pkg::ReadW-1:0] coarse_gather = '0;

  // Generator side bookkeeping: where the queued stream stands inside a frame.
  int gen_pos       = 0;
  bit drift_ok      = 1'b0;
  int items_queued  = 0;

  // Handshake and idling bookkeeping.
  logic in_taken      = 1'b0;
  int   tx_gap_left   = 0;
  bit   tx_calm       = 1'b0;
  int   rx_stall_left = 0;
  int   rx_hold_left  = 0;
  bit   rx_calm       = 1'b0;
  int   long_hold_requests = 0;
  int   long_holds_started = 0;
  pfp_pkg::item_t offer_item;

  // Run statistics.
  int mismatch_count   = 0;
  int items_taken      = 0;
  int flushes_taken    = 0;
  int results_checked  = 0;
  int checksum_results = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Most picks give no idle stretch; of the rest, a few are long enough to back things up.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // Advance the frame tracker by one accepted item. A byte at the last position closes
  // the frame; only a frame whose header matched owes a result, and a checksum miss
  // zeroes both readings.
  task automatic track_frame_byte(input pfp_pkg::item_t it);
    logic [pfp_pkg::PosW-1:0] pos;
    pfp_pkg::result_t         res;
    pos = frame_pos;
    if (it.kind == pfp_pkg::KIND_FLUSH) begin
      frame_pos = pfp_pkg::PosHdr0;
      flushes_taken++;
    end else begin
      if (pos > pfp_pkg::PosLast) begin
        pos = pfp_pkg::PosHdr0;
      end
      if (pos == pfp_pkg::PosHdr0) begin
        frame_hdr_ok = (it.rx_byte == pfp_pkg::Hdr0Byte);
        frame_sum    = '0;
      end else if (pos == pfp_pkg::PosLast) begin
        if (frame_hdr_ok) begin
          if (frame_sum == it.rx_byte) begin
            res.status         = pfp_pkg::STATUS_GOOD;
            res.fine_reading   = fine_gather;
            res.coarse_reading = coarse_gather;
          end else begin
            res.status         = pfp_pkg::STATUS_CHECKSUM;
            res.fine_reading   = '0;
            res.coarse_reading = '0;
          end
          due_readings_q.push_back(res);
        end
      end else begin
        if (pos == pfp_pkg::PosHdr1) begin
          frame_hdr_ok = frame_hdr_ok && (it.rx_byte == pfp_pkg::Hdr1Byte);
        end
        frame_sum = frame_sum + it.rx_byte;
        case (pos)
          pfp_pkg::PosFineHi:   fine_gather[15:8]   = it.rx_byte;
          pfp_pkg::PosFineLo:   fine_gather[7:0]    = it.rx_byte;
          pfp_pkg::PosCoarseHi: coarse_gather[15:8] = it.rx_byte;
          pfp_pkg::PosCoarseLo: coarse_gather[7:0]  = it.rx_byte;
          default: ;
        endcase
      end
      frame_pos = (pos == pfp_pkg::PosLast) ? pfp_pkg::PosHdr0 : pos + 1'b1;
    end
  endtask

  task automatic queue_item(input pfp_pkg::kind_e k, input logic [pfp_pkg::ByteW-1:0] b);
    pfp_pkg::item_t it;
    it.kind    = k;
    it.rx_byte = b;
    sensor_bytes_q.push_back(it);
    items_queued++;
    if (k == pfp_pkg::KIND_FLUSH) begin
      gen_pos = 0;
    end else begin
      gen_pos = (gen_pos == 10) ? 0 : gen_pos + 1;
    end
  endtask

  // Readings lean toward the all-zero and all-one extremes now and then.
  function automatic logic [pfp_pkg::ReadW-1:0] pick_reading();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end else begin
      return pfp_pkg::ReadW'($urandom_range(0, 65535));
    end
  endfunction

  // Queue one group of bytes of the given shape. Unless it is noise or the previous group
  // may drift off the frame boundary, a flush first brings the stream back to position 0.
  task automatic queue_frame(input frame_shape_e shape,
                             input logic [pfp_pkg::ReadW-1:0] fine,
                             input logic [pfp_pkg::ReadW-1:0] coarse);
    logic [pfp_pkg::ByteW-1:0] fb [11];
    logic [pfp_pkg::ByteW-1:0] sum;
    int                        n;
    if (shape == SHAPE_NOISE) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        queue_item(pfp_pkg::KIND_BYTE, pfp_pkg::ByteW'($urandom_range(0, 255)));
      end
      // Now and then the stream is left misaligned, so that the next frame is parsed
      // across the boundary and mostly dies on its header.
      if ($urandom_range(0, 99) < 70) begin
        queue_item(pfp_pkg::KIND_FLUSH, pfp_pkg::ByteW'($urandom_range(0, 255)));
      end else begin
        drift_ok = 1'b1;
      end
    end else begin
      if (gen_pos != 0 && !drift_ok) begin
        queue_item(pfp_pkg::KIND_FLUSH, pfp_pkg::ByteW'($urandom_range(0, 255)));
      end
      drift_ok = 1'b0;
      fb[0] = pfp_pkg::Hdr0Byte;
      fb[1] = pfp_pkg::Hdr1Byte;
      for (int i = 2; i < 6; i++) begin
        fb[i] = pfp_pkg::ByteW'($urandom_range(0, 255));
      end
      fb[6] = fine[15:8];
      fb[7] = fine[7:0];
      fb[8] = coarse[15:8];
      fb[9] = coarse[7:0];
      sum = '0;
      for (int i = 1; i < 10; i++) begin
        sum = sum + fb[i];
      end
      fb[10] = sum;
      case (shape)
        SHAPE_BAD_SUM:  fb[10] = sum ^ pfp_pkg::ByteW'($urandom_range(1, 255));
        SHAPE_BAD_HDR0: fb[0]  = pfp_pkg::Hdr0Byte ^ pfp_pkg::ByteW'($urandom_range(1, 255));
        SHAPE_BAD_HDR1: fb[1]  = pfp_pkg::Hdr1Byte ^ pfp_pkg::ByteW'($urandom_range(1, 255));
        default: ;
      endcase
      n = (shape == SHAPE_CUT) ? $urandom_range(1, 10) : 11;
      for (int i = 0; i < n; i++) begin
        queue_item(pfp_pkg::KIND_BYTE, fb[i]);
      end
      if (shape == SHAPE_CUT) begin
        queue_item(pfp_pkg::KIND_FLUSH, pfp_pkg::ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic frame_shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return SHAPE_GOOD;
    end else if (r < 70) begin
      return SHAPE_BAD_SUM;
    end else if (r < 77) begin
      return SHAPE_BAD_HDR0;
    end else if (r < 84) begin
      return SHAPE_BAD_HDR1;
    end else if (r < 92) begin
      return SHAPE_CUT;
    end else begin
      return SHAPE_NOISE;
    end
  endfunction

  // The sender stops until everything queued has been taken and every owed result has
  // come back.
  task automatic wait_drained();
    while (sensor_bytes_q.size() != 0 || in_ch.valid || due_readings_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender. Items change on the falling edge; a new item is offered only once the current
  // one was taken at the previous rising edge, and a random gap may follow each item.
  // Calm stretches, entered and left at random, send back to back.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_ch.valid <= 1'b0;
      end else if (sensor_bytes_q.size() > 0) begin
        offer_item = sensor_bytes_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= offer_item.kind;
        in_ch.rx_byte <= offer_item.rx_byte;
        if ($urandom_range(0, 99) < 3) begin
          tx_calm = !tx_calm;
        end
        tx_gap_left = tx_calm ? 0 : pick_idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. Besides the short random stalls it honors requests for one long hold-off,
  // counted here in cycles, which lets results pile up until the parser stops taking
  // input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_hold_left == 0 && long_holds_started < long_hold_requests) begin
        long_holds_started++;
        rx_hold_left = LongHoldCycles;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 3) begin
          rx_calm = !rx_calm;
        end
        if (!rx_calm && $urandom_range(0, 99) < 25) begin
          rx_stall_left = pick_idle_len();
        end
      end
    end
  end

  // Monitor. On each rising edge a delivered result is checked against the oldest owed
  // one before the item accepted at the same edge is tracked; that item's own result can
  // only show up at a later edge.
  always @(posedge clk_i) begin
    pfp_pkg::result_t want;
    pfp_pkg::item_t   got_item;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (out_ch.status == pfp_pkg::STATUS_CHECKSUM) begin
          checksum_results++;
        end
        if (due_readings_q.size() == 0) begin
          report_mismatch("unexpected result status", 32'(out_ch.status), 32'(0));
        end else begin
          want = due_readings_q.pop_front();
          if (out_ch.status !== want.status) begin
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          end
          if (out_ch.fine_reading !== want.fine_reading) begin
            report_mismatch("fine_reading", 32'(out_ch.fine_reading),
                            32'(want.fine_reading));
          end
          if (out_ch.coarse_reading !== want.coarse_reading) begin
            report_mismatch("coarse_reading", 32'(out_ch.coarse_reading),
                            32'(want.coarse_reading));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_item.kind    = in_ch.kind;
        got_item.rx_byte = in_ch.rx_byte;
        track_frame_byte(got_item);
        items_taken++;
      end
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // Stimulus sequence.
  initial begin
    int queued_before;
    in_ch.valid   = 1'b0;
    in_ch.kind    = pfp_pkg::KIND_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a flush on an empty frame, a good frame with both reading extremes, a
    // partial frame dropped by a flush whose data byte is all ones, then a frame with a
    // wrong checksum and the opposite reading extremes.
    queue_item(pfp_pkg::KIND_FLUSH, '0);
    queue_frame(SHAPE_GOOD, 16'hFFFF, 16'h0000);
    queue_item(pfp_pkg::KIND_BYTE, pfp_pkg::Hdr0Byte);
    queue_item(pfp_pkg::KIND_BYTE, pfp_pkg::Hdr1Byte);
    queue_item(pfp_pkg::KIND_BYTE, 8'h7F);
    queue_item(pfp_pkg::KIND_FLUSH, 8'hFF);
    queue_frame(SHAPE_BAD_SUM, 16'h0000, 16'hFFFF);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering good frames, so the result
    // path backs up into the input.
    long_hold_requests++;
    for (int i = 0; i < 15; i++) begin
      queue_frame(SHAPE_GOOD, pick_reading(), pick_reading());
    end
    wait_drained();

    // Random mix, with the sender pausing until everything is back every few hundred items.
    while (items_queued < TotalItems) begin
      queued_before = items_queued;
      queue_frame(pick_shape(), pick_reading(), pick_reading());
      if (items_queued / PauseEvery != queued_before / PauseEvery) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d items with %0d flushes; %0d results checked, %0d checksum errors",
             items_taken, flushes_taken, results_checked, checksum_results);
    if (mismatch_count == 0 && due_readings_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run with every gap and stall at its longest.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pfp_pkg.sv
rtl/core/pfp_in_if.sv
rtl/core/pfp_out_if.sv
rtl/core/pfp_in_stage.sv
rtl/core/pfp_frame_core.sv
rtl/core/pfp_out_stage.sv
rtl/core/particulate_frame_parser_unit.sv
bench/particulate_frame_parser_unit_test.sv
